/* hdl/tkmf_pkg.sv */
`default_nettype none
package tkmf_pkg;

  localparam int unsigned NodeCountDef   = 4096;
  localparam int unsigned WindowBytesDef = 32;

  localparam int unsigned CharW  = 8;
  localparam int unsigned TypeW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW   = 64;
  localparam logic [CharW-1:0] ReplaceRst = 8'd42;

  // request kinds
  typedef enum logic [TypeW-1:0] {
    REQ_KEY_BYTE = 2'd0,
    REQ_KEY_END  = 2'd1,
    REQ_TEXT     = 2'd2,
    REQ_TEXT_END = 2'd3
  } req_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    ST_TEXT   = 2'd0,
    ST_KEY_OK = 2'd1,
    ST_FULL   = 2'd2,
    ST_EOT    = 2'd3
  } stat_e;

  // config register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_REPLACE = 3'd0,
    CFG_MASK0   = 3'd1,
    CFG_MASK1   = 3'd2,
    CFG_MASK2   = 3'd3,
    CFG_MASK3   = 3'd4
  } cfg_e;

  // node pointer source for the read/walk register
  typedef enum logic [2:0] {
    X_HOLD, X_ROOT, X_CURSOR, X_RDCHILD, X_RDSIB, X_CC, X_COUNT
  } xsel_e;

  typedef enum logic [3:0] {
    S_IDLE, S_KB_START, S_KB_FIRST, S_KB_X, S_KB_ALLOC, S_KB_LINK, S_KEND,
    S_SC_START, S_SC_BYTE, S_SC_SIB, S_DECIDE, S_EMIT, S_END, S_FLUSH
  } state_e;

  typedef struct packed {
    xsel_e x_sel;
    logic  last_clr;
    logic  last_x;
    logic  cursor_x;
    logic  alloc;
    logic  link;
    logic  fail_set;
    logic  kend;
    logic  sc_init;
    logic  i_inc;
    logic  sc_step;
    logic  alive_set;
    logic  alive_val;
    logic  decide;
    logic  trunc_val;
    logic  emit;
    logic  push_end;
    logic  flush;
  } cmd_t;

  typedef struct packed {
    logic x_zero;
    logic key_match;
    logic scan_match;
    logic sib_zero;
    logic cc_zero;
    logic i_eq_fill;
    logic ignored;
    logic fill_zero;
    logic fill_full;
    logic rem_one;
    logic cursor_zero;
    logic count_full;
    logic fail;
    logic alive;
    logic can_push;
    logic can_flush;
  } stat_t;

  // fold A-Z to a-z
  function automatic logic [CharW-1:0] fold(input logic [CharW-1:0] b);
    logic [CharW-1:0] r;
    r = b;
    if (b >= 8'd65 && b <= 8'd90) r = b + 8'd32;
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/tkmf_ctrl.sv */
`default_nettype none
module tkmf_ctrl
  import tkmf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [TypeW-1:0]  in_type_i,
  output logic                   in_ready_o,
  input  wire stat_t             st_i,
  output cmd_t                   cmd_o
);

  state_e state_q, state_d;
  logic   final_q, final_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    final_d    = final_q;
    cmd_o      = '0;
    cmd_o.x_sel = X_HOLD;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (req_e'(in_type_i))
            REQ_KEY_BYTE: state_d = S_KB_START;
            REQ_KEY_END:  state_d = S_KEND;
            REQ_TEXT: begin
              final_d = 1'b0;
              state_d = S_SC_START;
            end
            REQ_TEXT_END: begin
              final_d = 1'b1;
              state_d = S_SC_START;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      // keyword insert: find child of cursor
      S_KB_START: begin
        cmd_o.last_clr = 1'b1;
        if (st_i.fail) begin
          state_d = S_FLUSH;
        end else if (st_i.cursor_zero) begin
          cmd_o.x_sel = X_ROOT;
          state_d = S_KB_X;
        end else begin
          cmd_o.x_sel = X_CURSOR;
          state_d = S_KB_FIRST;
        end
      end
      S_KB_FIRST: begin
        cmd_o.x_sel = X_RDCHILD;
        state_d = S_KB_X;
      end
      // walk the sibling chain, one node a cycle
      S_KB_X: begin
        if (st_i.x_zero) begin
          state_d = S_KB_ALLOC;
        end else if (st_i.key_match) begin
          cmd_o.cursor_x = 1'b1;
          state_d = S_FLUSH;
        end else begin
          cmd_o.last_x = 1'b1;
          cmd_o.x_sel = X_RDSIB;
        end
      end
      S_KB_ALLOC: begin
        if (st_i.count_full) begin
          cmd_o.fail_set = 1'b1;
          state_d = S_FLUSH;
        end else begin
          cmd_o.alloc = 1'b1;
          cmd_o.x_sel = X_COUNT;
          state_d = S_KB_LINK;
        end
      end
      S_KB_LINK: begin
        cmd_o.link = 1'b1;
        cmd_o.cursor_x = 1'b1;
        state_d = S_FLUSH;
      end
      S_KEND: begin
        if (st_i.can_push) begin
          cmd_o.kend = 1'b1;
          state_d = S_FLUSH;
        end
      end
      // one scan from the window start
      S_SC_START: begin
        cmd_o.sc_init = 1'b1;
        if (st_i.fill_zero) state_d = final_q ? S_END : S_FLUSH;
        else state_d = S_SC_BYTE;
      end
      S_SC_BYTE: begin
        if (st_i.i_eq_fill) begin
          cmd_o.alive_set = 1'b1;
          cmd_o.alive_val = !st_i.cc_zero;
          state_d = S_DECIDE;
        end else if (st_i.ignored) begin
          cmd_o.i_inc = 1'b1;
        end else if (st_i.cc_zero) begin
          cmd_o.alive_set = 1'b1;
          state_d = S_DECIDE;
        end else begin
          cmd_o.x_sel = X_CC;
          state_d = S_SC_SIB;
        end
      end
      S_SC_SIB: begin
        if (st_i.scan_match) begin
          cmd_o.sc_step = 1'b1;
          state_d = S_SC_BYTE;
        end else if (st_i.sib_zero) begin
          cmd_o.alive_set = 1'b1;
          state_d = S_DECIDE;
        end else begin
          cmd_o.x_sel = X_RDSIB;
        end
      end
      S_DECIDE: begin
        if (st_i.alive && !final_q && !st_i.fill_full) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.decide = 1'b1;
          cmd_o.trunc_val = st_i.alive && !final_q;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st_i.can_push) begin
          cmd_o.emit = 1'b1;
          if (st_i.rem_one) state_d = S_SC_START;
        end
      end
      S_END: begin
        if (st_i.can_push) begin
          cmd_o.push_end = 1'b1;
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (st_i.can_flush) begin
          cmd_o.flush = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/tkmf_dp.sv */
`default_nettype none
module tkmf_dp
  import tkmf_pkg::*;
#(
  parameter int unsigned NODE_COUNT   = NodeCountDef,
  parameter int unsigned WINDOW_BYTES = WindowBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_acc_i,
  input  wire logic [TypeW-1:0]   in_type_i,
  input  wire logic [CharW-1:0]   in_char_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [CharW-1:0]        out_char_o,
  output logic [StatW-1:0]        out_status_o,
  output logic                    out_found_o,
  output logic                    out_trunc_o,
  output logic                    out_last_o,
  input  wire cmd_t               cmd_i,
  output stat_t                   st_o
);

  localparam int unsigned NW = $clog2(NODE_COUNT);
  localparam int unsigned CW = $clog2(NODE_COUNT + 1);
  localparam int unsigned IW = $clog2(WINDOW_BYTES);
  localparam int unsigned FW = $clog2(WINDOW_BYTES + 1);

  // node memories, undefined until allocated; root child kept in a flop
  logic [NW-1:0]    child_mem [NODE_COUNT];
  logic [NW-1:0]    sib_mem   [NODE_COUNT];
  logic [CharW-1:0] ch_mem    [NODE_COUNT];
  logic             end_mem   [NODE_COUNT];
  logic [NW-1:0]    rd_child_q, rd_sib_q;
  logic [CharW-1:0] rd_ch_q;
  logic             rd_end_q;

  logic [NW-1:0]    root_child_q, x_q, x_d, cursor_q, last_q, cc_q;
  logic [CW-1:0]    count_q;
  logic             fail_q, match_q, alive_q, trunc_q, use_rep_q;
  logic [CharW-1:0] key_q, replace_q;
  logic [4*CfgW-1:0] mask_q;
  logic [CharW-1:0] win_q [WINDOW_BYTES];
  logic [FW-1:0]    fill_q, i_q, best_q, rem_q;
  logic [CharW-1:0] cur_b;
  logic [NW-1:0]    new_idx;

  // pending and output result registers
  logic             p_valid_q, o_valid_q;
  logic [CharW-1:0] p_char_q;
  logic [StatW-1:0] p_stat_q;
  logic             p_found_q, p_trunc_q;
  logic             push;
  logic [CharW-1:0] r_char;
  logic [StatW-1:0] r_stat;
  logic             r_found, r_trunc;
  logic             o_load;

  assign cur_b   = win_q[i_q[IW-1:0]];
  assign new_idx = count_q[NW-1:0];

  // walk pointer select; it also addresses the node memories
  always_comb begin
    case (cmd_i.x_sel)
      X_ROOT:    x_d = root_child_q;
      X_CURSOR:  x_d = cursor_q;
      X_RDCHILD: x_d = rd_child_q;
      X_RDSIB:   x_d = rd_sib_q;
      X_CC:      x_d = cc_q;
      X_COUNT:   x_d = new_idx;
      default:   x_d = x_q;
    endcase
  end

  // node memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) child_mem[new_idx] <= '0;
    else if (cmd_i.link && last_q == '0 && cursor_q != '0) child_mem[cursor_q] <= x_q;
    rd_child_q <= child_mem[x_d];
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) sib_mem[new_idx] <= '0;
    else if (cmd_i.link && last_q != '0) sib_mem[last_q] <= x_q;
    rd_sib_q <= sib_mem[x_d];
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) ch_mem[new_idx] <= key_q;
    rd_ch_q <= ch_mem[x_d];
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) end_mem[new_idx] <= 1'b0;
    else if (cmd_i.kend && !fail_q) end_mem[cursor_q] <= 1'b1;
    rd_end_q <= end_mem[x_d];
  end

  // trie control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_child_q <= '0;
      count_q      <= CW'(1);
      cursor_q     <= '0;
      fail_q       <= 1'b0;
      last_q       <= '0;
      x_q          <= '0;
    end else begin
      x_q <= x_d;
      if (cmd_i.last_clr) last_q <= '0;
      else if (cmd_i.last_x) last_q <= x_q;
      if (cmd_i.alloc) count_q <= count_q + CW'(1);
      if (cmd_i.link && last_q == '0 && cursor_q == '0) root_child_q <= x_q;
      if (cmd_i.fail_set) fail_q <= 1'b1;
      else if (cmd_i.kend) fail_q <= 1'b0;
      if (cmd_i.kend) cursor_q <= '0;
      else if (cmd_i.cursor_x) cursor_q <= x_q;
    end
  end

  // key byte capture
  always_ff @(posedge clk_i) begin
    if (in_acc_i) key_q <= fold(in_char_i);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replace_q <= ReplaceRst;
      mask_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_REPLACE: replace_q <= cfg_data_i[CharW-1:0];
        CFG_MASK0:   mask_q[0*CfgW +: CfgW] <= cfg_data_i;
        CFG_MASK1:   mask_q[1*CfgW +: CfgW] <= cfg_data_i;
        CFG_MASK2:   mask_q[2*CfgW +: CfgW] <= cfg_data_i;
        CFG_MASK3:   mask_q[3*CfgW +: CfgW] <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // text window: append on request, shift one byte per emitted result
  always_ff @(posedge clk_i) begin
    if (in_acc_i && req_e'(in_type_i) == REQ_TEXT && fill_q < FW'(WINDOW_BYTES)) begin
      win_q[fill_q[IW-1:0]] <= in_char_i;
    end else if (cmd_i.emit) begin
      for (int k = 0; k < WINDOW_BYTES - 1; k++) win_q[k] <= win_q[k+1];
    end
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      match_q   <= 1'b0;
      i_q       <= '0;
      best_q    <= '0;
      rem_q     <= '0;
      cc_q      <= '0;
      alive_q   <= 1'b0;
      trunc_q   <= 1'b0;
      use_rep_q <= 1'b0;
    end else begin
      if (in_acc_i && req_e'(in_type_i) == REQ_TEXT && fill_q < FW'(WINDOW_BYTES)) begin
        fill_q <= fill_q + FW'(1);
      end else if (cmd_i.emit) begin
        fill_q <= fill_q - FW'(1);
      end
      if (cmd_i.sc_init) begin
        cc_q   <= root_child_q;
        i_q    <= '0;
        best_q <= '0;
      end else if (cmd_i.sc_step) begin
        cc_q <= rd_child_q;
        i_q  <= i_q + FW'(1);
        if (rd_end_q) best_q <= i_q + FW'(1);
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + FW'(1);
      end
      if (cmd_i.alive_set) alive_q <= cmd_i.alive_val;
      if (cmd_i.decide) begin
        trunc_q   <= cmd_i.trunc_val;
        use_rep_q <= best_q != '0;
        rem_q     <= (best_q != '0) ? best_q : FW'(1);
        if (best_q != '0) match_q <= 1'b1;
      end else if (cmd_i.emit) begin
        rem_q <= rem_q - FW'(1);
      end else if (cmd_i.push_end) begin
        match_q <= 1'b0;
      end
    end
  end

  // result source
  always_comb begin
    push    = cmd_i.emit | cmd_i.push_end | cmd_i.kend;
    r_char  = '0;
    r_stat  = ST_TEXT;
    r_found = 1'b0;
    r_trunc = 1'b0;
    if (cmd_i.emit) begin
      r_char  = use_rep_q ? replace_q : win_q[0];
      r_trunc = trunc_q;
    end else if (cmd_i.push_end) begin
      r_stat  = ST_EOT;
      r_found = match_q;
    end else if (cmd_i.kend) begin
      r_stat = fail_q ? ST_FULL : ST_KEY_OK;
    end
  end

  // held result moves out once the next one is known, or at item end as last
  assign o_load = p_valid_q && (push || cmd_i.flush);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (push) p_valid_q <= 1'b1;
      else if (cmd_i.flush) p_valid_q <= 1'b0;
      if (o_load) o_valid_q <= 1'b1;
      else if (out_ready_i) o_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) begin
      p_char_q  <= r_char;
      p_stat_q  <= r_stat;
      p_found_q <= r_found;
      p_trunc_q <= r_trunc;
    end
    if (o_load) begin
      out_char_o   <= p_char_q;
      out_status_o <= p_stat_q;
      out_found_o  <= p_found_q;
      out_trunc_o  <= p_trunc_q;
      out_last_o   <= cmd_i.flush;
    end
  end
  assign out_valid_o = o_valid_q;

  // status to the controller
  always_comb begin
    st_o.x_zero      = x_q == '0;
    st_o.key_match   = rd_ch_q == key_q;
    st_o.scan_match  = rd_ch_q == fold(cur_b);
    st_o.sib_zero    = rd_sib_q == '0;
    st_o.cc_zero     = cc_q == '0;
    st_o.i_eq_fill   = i_q == fill_q;
    st_o.ignored     = mask_q[cur_b];
    st_o.fill_zero   = fill_q == '0;
    st_o.fill_full   = fill_q == FW'(WINDOW_BYTES);
    st_o.rem_one     = rem_q == FW'(1);
    st_o.cursor_zero = cursor_q == '0;
    st_o.count_full  = count_q >= CW'(NODE_COUNT);
    st_o.fail        = fail_q;
    st_o.alive       = alive_q;
    st_o.can_push    = !p_valid_q || !o_valid_q || out_ready_i;
    st_o.can_flush   = !o_valid_q || out_ready_i;
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(WINDOW_BYTES)) else $error("window overfilled");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 && count_q <= CW'(NODE_COUNT)) else $error("node count out of range");
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> fill_q != '0) else $error("emit from empty window");
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> !p_valid_q) else $error("held result not flushed");
`endif

endmodule
`default_nettype wire

/* hdl/trie_keyword_mask_filter.sv */
// Each request is accepted in idle, then: a keyword byte walks the cursor's children
// along the sibling chain and adds a node when none matches; keyword end pushes a status.
// Text byte: each scan walks the window from its start through the node memory, skipping
// masked bytes; every decided byte then leaves at one a cycle while the output takes it,
// and the window is rescanned. One request at a time; the last result leaves marked last.
// Reset clears control state; node memory is not cleared (root held in flops).
`default_nettype none
module trie_keyword_mask_filter
  import tkmf_pkg::*;
#(
  parameter int unsigned NODE_COUNT   = NodeCountDef,
  parameter int unsigned WINDOW_BYTES = WindowBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,   // [7:0] char_in
  input  wire logic [1:0]         s_axis_tuser,   // [1:0] req_type
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [15:0]             m_axis_tdata,   // [7:0] out_char, [8] found_any,
                                                  // [9] truncated, zero above
  output logic [1:0]              m_axis_tuser,   // [1:0] status
  output logic                    m_axis_tlast,   // is_last
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  cmd_t             cmd;
  stat_t            st;
  logic             in_acc;
  logic [CharW-1:0] o_char;
  logic             o_found, o_trunc;

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  tkmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_type_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  tkmf_dp #(
    .NODE_COUNT   (NODE_COUNT),
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_acc_i     (in_acc),
    .in_type_i    (s_axis_tuser),
    .in_char_i    (s_axis_tdata),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_char_o   (o_char),
    .out_status_o (m_axis_tuser),
    .out_found_o  (o_found),
    .out_trunc_o  (o_trunc),
    .out_last_o   (m_axis_tlast),
    .cmd_i        (cmd),
    .st_o         (st)
  );

  assign m_axis_tdata = {6'd0, o_trunc, o_found, o_char};

endmodule
`default_nettype wire
